// File: rtl/core/ddng_pkg.sv
`timescale 1ns / 1ps

package ddng_pkg;

   // store depth, bins per frame at most
   localparam int MAX_BINS  = 512;
   localparam int BIN_W     = $clog2(MAX_BINS);
   localparam int FRAME_W   = 10;
   localparam int EFF_W     = ($clog2(MAX_BINS + 1) > FRAME_W) ? $clog2(MAX_BINS + 1) : FRAME_W;

   localparam int AMP_W     = 16;
   localparam int Q16_W     = 16;
   localparam int NP_W      = 32;
   localparam int SNR_W     = 32;
   localparam int NUM_W     = 48;
   localparam int DEN_W     = 33;
   localparam int DIV_STEPS = 32;

   // beats in flight before the store write: 140 at most
   localparam int INFL_W    = 8;

   localparam int IDX_W     = 8;
   localparam int CSR_W     = 16;

   localparam logic [SNR_W-1:0] SNR_MAX = '1;
   localparam logic [SNR_W-1:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      MODE_WIENER    = 2'd0,
      MODE_TSNR      = 2'd1,
      MODE_RTSNR     = 2'd2,
      MODE_RTSNR_ALT = 2'd3
   } mode_type;

   localparam logic [IDX_W-1:0] REG_MODE   = 8'd0;
   localparam logic [IDX_W-1:0] REG_SMOOTH = 8'd1;
   localparam logic [IDX_W-1:0] REG_FLOOR  = 8'd2;
   localparam logic [IDX_W-1:0] REG_FRAME  = 8'd3;

   localparam logic [CSR_W-1:0]   SMOOTH_RST = 16'd64225;
   localparam logic [CSR_W-1:0]   FLOOR_RST  = 16'd655;
   localparam logic [FRAME_W-1:0] FRAME_RST  = 10'd512;

   // what rides along with a bin through the divider pipes
   typedef struct packed {
      logic [AMP_W-1:0] y;
      logic [NP_W-1:0]  np;
      logic [BIN_W-1:0] bin;
      logic             last;
      logic             sat;
      logic [Q16_W-1:0] gain;
      logic [AMP_W-1:0] early;
   } side_type;

endpackage

// File: rtl/core/ddng_ram.sv
`timescale 1ns / 1ps

module ddng_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ddng_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. Needs num[47:32] < den.
module ddng_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [ddng_pkg::NUM_W-1:0]       in_num,
   input  logic [ddng_pkg::DEN_W-1:0]       in_den,
   input  ddng_pkg::side_type               in_side,
   output logic                             out_valid,
   output logic [ddng_pkg::DIV_STEPS-1:0]   out_quo,
   output ddng_pkg::side_type               out_side
);

   localparam int N = ddng_pkg::DIV_STEPS;
   localparam int D = ddng_pkg::DEN_W;

   logic [D-1:0]      rem_src  [N];
   logic [D-1:0]      rem_in   [N];
   logic [D-1:0]      rem_ff   [N];
   logic [N-1:0]      work_src [N];
   logic [N-1:0]      work_in  [N];
   logic [N-1:0]      work_ff  [N];
   logic [D-1:0]      den_src  [N];
   logic [D-1:0]      den_ff   [N];
   logic [D+1:0]      trial    [N];
   ddng_pkg::side_type side_src [N];
   ddng_pkg::side_type side_ff  [N];
   logic [N-1:0]      valid_src;
   logic [N-1:0]      valid_ff;

   assign rem_src[0]   = D'(in_num[ddng_pkg::NUM_W-1:N]);
   assign work_src[0]  = in_num[N-1:0];
   assign den_src[0]   = in_den;
   assign side_src[0]  = in_side;
   assign valid_src[0] = in_valid;

   for (genvar k = 1; k < N; k++) begin : g_link
      assign rem_src[k]   = rem_ff[k-1];
      assign work_src[k]  = work_ff[k-1];
      assign den_src[k]   = den_ff[k-1];
      assign side_src[k]  = side_ff[k-1];
      assign valid_src[k] = valid_ff[k-1];
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         trial[k] = {1'b0, rem_src[k], work_src[k][N-1]} - {2'b00, den_src[k]};
         if (!trial[k][D+1]) begin
            rem_in[k]  = trial[k][D-1:0];
            work_in[k] = {work_src[k][N-2:0], 1'b1};
         end else begin
            rem_in[k]  = {rem_src[k][D-2:0], work_src[k][N-1]};
            work_in[k] = {work_src[k][N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo   = work_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// File: rtl/core/decision_directed_noise_gain_top.sv
`timescale 1ns / 1ps

// Decision-directed Wiener / two-step SNR noise suppressor, one spectral bin per beat.
// A req beat carries the noisy and noise amplitudes of the next bin; the rsp beat gives
// the cleaned amplitude, its bin number and a frame_end flag on the frame's last bin.
// Unless the pipe is frozen by rsp_stall or a bin is held off as below, a new
// bin is taken every cycle. The store of each bin's last cleaned amplitude is read
// when a bin enters and written when it leaves, so a bin is held off while the same
// bin of the previous frame is still in the pipe, which only frames of 140 bins or
// fewer can hit. The pipe holds 32-stage restoring dividers for the posterior and
// previous SNR (side by side), the first gain, the second SNR and the second gain.
// The store reads as zero until written after reset (fill mark), so there is no
// clearing pass: the block takes bins from the first cycle after reset.
// Registers are to be written over the csr port only while the block is idle, which
// the block itself does not enforce; csr_ready is always high.
module decision_directed_noise_gain_top (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ddng_pkg::AMP_W-1:0]       req_noisy_amp,
   input  logic [ddng_pkg::AMP_W-1:0]       req_noise_amp,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ddng_pkg::AMP_W-1:0]       rsp_clean_amp,
   output logic [ddng_pkg::BIN_W-1:0]       rsp_bin_number,
   output logic                             rsp_frame_end,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ddng_pkg::IDX_W-1:0]       csr_index,
   input  logic [ddng_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int BW = ddng_pkg::BIN_W;
   localparam int EW = ddng_pkg::EFF_W;

   // ---------------- configuration ----------------
   ddng_pkg::mode_type                mode_ff;
   logic [ddng_pkg::CSR_W-1:0]        smooth_ff;
   logic [ddng_pkg::CSR_W-1:0]        floor_ff;
   logic [ddng_pkg::FRAME_W-1:0]      frame_ff;
   logic                              csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ddng_pkg::MODE_WIENER;
         smooth_ff <= ddng_pkg::SMOOTH_RST;
         floor_ff  <= ddng_pkg::FLOOR_RST;
         frame_ff  <= ddng_pkg::FRAME_RST;
      end else if (csr_wr) begin
         case (csr_index)
            ddng_pkg::REG_MODE:   mode_ff   <= ddng_pkg::mode_type'(csr_wdata[1:0]);
            ddng_pkg::REG_SMOOTH: smooth_ff <= csr_wdata;
            ddng_pkg::REG_FLOOR:  floor_ff  <= csr_wdata;
            ddng_pkg::REG_FRAME:  frame_ff  <= csr_wdata[ddng_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame length, clamped to 2..MAX_BINS
   logic [EW-1:0] frame_ext;
   logic [EW-1:0] eff;

   assign frame_ext = EW'(frame_ff);
   always_comb begin
      if (frame_ext < EW'(2)) begin
         eff = EW'(2);
      end else if (frame_ext > EW'(ddng_pkg::MAX_BINS)) begin
         eff = EW'(ddng_pkg::MAX_BINS);
      end else begin
         eff = frame_ext;
      end
   end

   logic is_wiener;
   logic is_rtsnr;
   assign is_wiener = (mode_ff == ddng_pkg::MODE_WIENER);
   assign is_rtsnr  = mode_ff inside {ddng_pkg::MODE_RTSNR, ddng_pkg::MODE_RTSNR_ALT};

   // ---------------- flow control ----------------
   // Whole pipe moves together; it only freezes when the last stage holds a
   // result and the rsp register is full and stalled.
   logic                        s11_valid_ff;
   logic                        rsp_valid_ff;
   logic                        advance;
   logic                        accept;
   logic                        wr_en;
   logic [ddng_pkg::INFL_W-1:0] infl_ff;
   logic [ddng_pkg::INFL_W-1:0] infl_in;
   logic                        hazard;

   assign advance   = !(rsp_valid_ff && rsp_stall && s11_valid_ff);
   // a bin may not enter while its previous-frame twin is still unwritten
   assign hazard    = EW'(infl_ff) >= eff;
   assign req_stall = !advance || hazard;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = s11_valid_ff && advance;

   assign infl_in = infl_ff + ddng_pkg::INFL_W'(accept) - ddng_pkg::INFL_W'(wr_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         infl_ff <= '0;
      end else begin
         infl_ff <= infl_in;
      end
   end

   // ---------------- bin counter, fill mark ----------------
   logic [BW-1:0] bin_ff;
   logic [BW-1:0] bin_in;
   logic          last_now;
   logic [EW-1:0] fill_ff;
   logic [EW-1:0] fill_in;
   logic [BW-1:0] wr_bin;
   logic [ddng_pkg::AMP_W-1:0] clean;

   assign last_now = (EW'(bin_ff) + EW'(1)) >= eff;
   assign bin_in   = last_now ? '0 : bin_ff + BW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
      end else if (accept) begin
         bin_ff <= bin_in;
      end
   end

   // bins are written in order from 0, so everything below the mark is valid
   assign fill_in = (wr_en && (EW'(wr_bin) + EW'(1) > fill_ff)) ? EW'(wr_bin) + EW'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   logic [ddng_pkg::AMP_W-1:0] prev_rd;

   ddng_ram #(
      .WIDTH (ddng_pkg::AMP_W),
      .DEPTH (ddng_pkg::MAX_BINS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_bin),
      .wr_data (clean),
      .rd_en   (accept),
      .rd_addr (bin_ff),
      .rd_data (prev_rd)
   );

   // ---------------- S0: capture, squares of inputs ----------------
   logic                       s0_valid_ff;
   logic [ddng_pkg::AMP_W-1:0] s0_y_ff;
   logic [ddng_pkg::NP_W-1:0]  s0_np_ff;
   logic [ddng_pkg::NP_W-1:0]  s0_ysq_ff;
   logic [BW-1:0]              s0_bin_ff;
   logic                       s0_last_ff;
   logic                       s0_zero_ff;
   logic [ddng_pkg::NP_W-1:0]  np_in;
   logic [ddng_pkg::NP_W-1:0]  ysq_in;

   assign np_in  = ddng_pkg::NP_W'(req_noise_amp) * ddng_pkg::NP_W'(req_noise_amp);
   assign ysq_in = ddng_pkg::NP_W'(req_noisy_amp) * ddng_pkg::NP_W'(req_noisy_amp);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_y_ff    <= req_noisy_amp;
         s0_np_ff   <= np_in;
         s0_ysq_ff  <= ysq_in;
         s0_bin_ff  <= bin_ff;
         s0_last_ff <= last_now;
         s0_zero_ff <= EW'(bin_ff) >= fill_ff;
      end
   end

   // ---------------- S1: previous power, saturation flags ----------------
   logic                       s1_valid_ff;
   logic [ddng_pkg::AMP_W-1:0] s1_y_ff;
   logic [ddng_pkg::NP_W-1:0]  s1_np_ff;
   logic [ddng_pkg::NP_W-1:0]  s1_ysq_ff;
   logic [ddng_pkg::NP_W-1:0]  s1_psq_ff;
   logic [BW-1:0]              s1_bin_ff;
   logic                       s1_last_ff;
   logic                       s1_psat_ff;
   logic [ddng_pkg::AMP_W-1:0] prev_amp;
   logic [ddng_pkg::NP_W-1:0]  psq_in;
   logic                       psat_in;

   assign prev_amp = s0_zero_ff ? '0 : prev_rd;
   assign psq_in   = ddng_pkg::NP_W'(prev_amp) * ddng_pkg::NP_W'(prev_amp);
   // quotient would pass 32 bits, or no noise at all
   assign psat_in  = (s0_np_ff == '0) || (ddng_pkg::NP_W'(s0_ysq_ff[31:16]) >= s0_np_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_y_ff    <= s0_y_ff;
         s1_np_ff   <= s0_np_ff;
         s1_ysq_ff  <= s0_ysq_ff;
         s1_psq_ff  <= psq_in;
         s1_bin_ff  <= s0_bin_ff;
         s1_last_ff <= s0_last_ff;
         s1_psat_ff <= psat_in;
      end
   end

   // ---------------- divider A: posterior SNR and previous-frame SNR ----------------
   ddng_pkg::side_type          side_a_in;
   ddng_pkg::side_type          side_b_in;
   logic                        prev_sat;
   logic                        a_valid;
   logic                        b_valid;
   logic [ddng_pkg::SNR_W-1:0]  a_quo;
   logic [ddng_pkg::SNR_W-1:0]  b_quo;
   ddng_pkg::side_type          a_side;
   ddng_pkg::side_type          b_side;

   assign prev_sat = (s1_np_ff == '0) || (ddng_pkg::NP_W'(s1_psq_ff[31:16]) >= s1_np_ff);

   assign side_a_in = '{y: s1_y_ff, np: s1_np_ff, bin: s1_bin_ff, last: s1_last_ff,
                        sat: s1_psat_ff, gain: '0, early: '0};
   assign side_b_in = '{y: s1_y_ff, np: s1_np_ff, bin: s1_bin_ff, last: s1_last_ff,
                        sat: prev_sat, gain: '0, early: '0};

   ddng_div u_div_post (
      .clock (clock), .reset (reset), .advance (advance),
      .in_valid (s1_valid_ff), .in_num ({s1_ysq_ff, 16'h0000}), .in_den ({1'b0, s1_np_ff}),
      .in_side (side_a_in),
      .out_valid (a_valid), .out_quo (a_quo), .out_side (a_side)
   );

   ddng_div u_div_prev (
      .clock (clock), .reset (reset), .advance (advance),
      .in_valid (s1_valid_ff), .in_num ({s1_psq_ff, 16'h0000}), .in_den ({1'b0, s1_np_ff}),
      .in_side (side_b_in),
      .out_valid (b_valid), .out_quo (b_quo), .out_side (b_side)
   );

   // ---------------- S2: instantaneous SNR ----------------
   logic                       s2_valid_ff;
   ddng_pkg::side_type         s2_side_ff;
   logic [ddng_pkg::SNR_W-1:0] s2_inst_ff;
   logic [ddng_pkg::SNR_W-1:0] s2_psnr_ff;
   logic [ddng_pkg::SNR_W-1:0] post;
   logic [ddng_pkg::SNR_W-1:0] inst_raw;
   logic [ddng_pkg::SNR_W-1:0] inst_in;
   logic [ddng_pkg::SNR_W-1:0] psnr_in;
   logic [ddng_pkg::SNR_W-1:0] floor_ext;

   assign floor_ext = ddng_pkg::SNR_W'(floor_ff);
   assign post      = a_side.sat ? ddng_pkg::SNR_MAX : a_quo;
   assign psnr_in   = b_side.sat ? ddng_pkg::SNR_MAX : b_quo;
   assign inst_raw  = (post >= ddng_pkg::ONE_Q16) ? post - ddng_pkg::ONE_Q16 : '0;
   assign inst_in   = (inst_raw < floor_ext) ? floor_ext : inst_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= a_valid && b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_side_ff <= a_side;
         s2_inst_ff <= inst_in;
         s2_psnr_ff <= psnr_in;
      end
   end

   // ---------------- S3: smoothing products ----------------
   logic               s3_valid_ff;
   ddng_pkg::side_type s3_side_ff;
   logic [47:0]        s3_pa_ff;
   logic [48:0]        s3_pb_ff;
   logic [16:0]        beta_c;
   logic [47:0]        pa_in;
   logic [48:0]        pb_in;

   assign beta_c = 17'h1_0000 - {1'b0, smooth_ff};
   assign pa_in  = 48'(smooth_ff) * 48'(s2_psnr_ff);
   assign pb_in  = 49'(beta_c) * 49'(s2_inst_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff <= s2_side_ff;
         s3_pa_ff   <= pa_in;
         s3_pb_ff   <= pb_in;
      end
   end

   // ---------------- S4: a priori SNR ----------------
   logic                       s4_valid_ff;
   ddng_pkg::side_type         s4_side_ff;
   logic [ddng_pkg::SNR_W-1:0] s4_prio_ff;
   logic [49:0]                prio_sum;

   // weights sum to one, so the total stays below 2^48
   assign prio_sum = {2'b00, s3_pa_ff} + {1'b0, s3_pb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_side_ff <= s3_side_ff;
         s4_prio_ff <= prio_sum[47:16];
      end
   end

   // ---------------- S5: Wiener gain operands ----------------
   logic                       s5_valid_ff;
   ddng_pkg::side_type         s5_side_ff;
   logic [ddng_pkg::NUM_W-1:0] s5_num_ff;
   logic [ddng_pkg::DEN_W-1:0] s5_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_side_ff <= s4_side_ff;
         s5_num_ff  <= {s4_prio_ff, 16'h0000};
         s5_den_ff  <= {1'b0, s4_prio_ff} + {1'b0, ddng_pkg::ONE_Q16};
      end
   end

   logic                        c_valid;
   logic [ddng_pkg::SNR_W-1:0]  c_quo;
   ddng_pkg::side_type          c_side;

   ddng_div u_div_gain (
      .clock (clock), .reset (reset), .advance (advance),
      .in_valid (s5_valid_ff), .in_num (s5_num_ff), .in_den (s5_den_ff),
      .in_side (s5_side_ff),
      .out_valid (c_valid), .out_quo (c_quo), .out_side (c_side)
   );

   // ---------------- S6: first gain, plain Wiener result ----------------
   logic                       s6_valid_ff;
   ddng_pkg::side_type         s6_side_ff;
   logic [ddng_pkg::Q16_W-1:0] g;
   logic [17:0]                two_minus_g;
   logic [33:0]                rt_prod;
   logic [31:0]                early_prod;
   ddng_pkg::side_type         s6_side_in;

   assign g           = c_quo[ddng_pkg::Q16_W-1:0];
   assign two_minus_g = 18'h2_0000 - {2'b00, g};
   assign rt_prod     = 34'(two_minus_g) * 34'(g);
   assign early_prod  = 32'(g) * 32'(c_side.y);

   always_comb begin
      s6_side_in       = c_side;
      s6_side_in.gain  = is_rtsnr ? rt_prod[31:16] : g;
      s6_side_in.early = early_prod[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_side_ff <= s6_side_in;
      end
   end

   // ---------------- S7: first estimate S = g1*Y, Q16.16 ----------------
   logic               s7_valid_ff;
   ddng_pkg::side_type s7_side_ff;
   logic [31:0]        s7_s_ff;
   logic [31:0]        s_in;

   assign s_in = 32'(s6_side_ff.gain) * 32'(s6_side_ff.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_side_ff <= s6_side_ff;
         s7_s_ff    <= s_in;
      end
   end

   // ---------------- S8: S squared ----------------
   logic                       s8_valid_ff;
   ddng_pkg::side_type         s8_side_ff;
   logic [ddng_pkg::NUM_W-1:0] s8_num_ff;
   logic [63:0]                ssq;

   assign ssq = 64'(s7_s_ff) * 64'(s7_s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_side_ff <= s7_side_ff;
         s8_num_ff  <= ssq[63:16];
      end
   end

   // ---------------- S9: second SNR saturation ----------------
   logic                       s9_valid_ff;
   ddng_pkg::side_type         s9_side_ff;
   logic [ddng_pkg::NUM_W-1:0] s9_num_ff;
   ddng_pkg::side_type         s9_side_in;

   always_comb begin
      s9_side_in     = s8_side_ff;
      s9_side_in.sat = (s8_side_ff.np == '0) ||
                       (ddng_pkg::NP_W'(s8_num_ff[47:32]) >= s8_side_ff.np);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (advance) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s9_side_ff <= s9_side_in;
         s9_num_ff  <= s8_num_ff;
      end
   end

   logic                        d_valid;
   logic [ddng_pkg::SNR_W-1:0]  d_quo;
   ddng_pkg::side_type          d_side;

   ddng_div u_div_snr2 (
      .clock (clock), .reset (reset), .advance (advance),
      .in_valid (s9_valid_ff), .in_num (s9_num_ff), .in_den ({1'b0, s9_side_ff.np}),
      .in_side (s9_side_ff),
      .out_valid (d_valid), .out_quo (d_quo), .out_side (d_side)
   );

   // ---------------- S10: second gain operands ----------------
   logic                       s10_valid_ff;
   ddng_pkg::side_type         s10_side_ff;
   logic [ddng_pkg::NUM_W-1:0] s10_num_ff;
   logic [ddng_pkg::DEN_W-1:0] s10_den_ff;
   logic [ddng_pkg::SNR_W-1:0] snr2;

   assign snr2 = d_side.sat ? ddng_pkg::SNR_MAX : d_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (advance) begin
         s10_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s10_side_ff <= d_side;
         s10_num_ff  <= {snr2, 16'h0000};
         s10_den_ff  <= {1'b0, snr2} + {1'b0, ddng_pkg::ONE_Q16};
      end
   end

   logic                        e_valid;
   logic [ddng_pkg::SNR_W-1:0]  e_quo;
   ddng_pkg::side_type          e_side;

   ddng_div u_div_gain2 (
      .clock (clock), .reset (reset), .advance (advance),
      .in_valid (s10_valid_ff), .in_num (s10_num_ff), .in_den (s10_den_ff),
      .in_side (s10_side_ff),
      .out_valid (e_valid), .out_quo (e_quo), .out_side (e_side)
   );

   // ---------------- S11: floored second gain ----------------
   ddng_pkg::side_type         s11_side_ff;
   logic [ddng_pkg::Q16_W-1:0] s11_g2_ff;
   logic [ddng_pkg::Q16_W-1:0] g2;

   assign g2 = e_quo[ddng_pkg::Q16_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (advance) begin
         s11_valid_ff <= e_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s11_side_ff <= e_side;
         s11_g2_ff   <= (g2 < floor_ff) ? floor_ff : g2;
      end
   end

   // ---------------- result register, store write ----------------
   logic [31:0]                final_prod;
   logic                       rsp_valid_in;
   logic [ddng_pkg::AMP_W-1:0] rsp_clean_ff;
   logic [BW-1:0]              rsp_bin_ff;
   logic                       rsp_end_ff;

   assign final_prod = 32'(s11_g2_ff) * 32'(s11_side_ff.y);
   assign clean      = is_wiener ? s11_side_ff.early : final_prod[31:16];
   assign wr_bin     = s11_side_ff.bin;

   always_comb begin
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_clean_ff <= clean;
         rsp_bin_ff   <= s11_side_ff.bin;
         rsp_end_ff   <= s11_side_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clean_amp  = rsp_clean_ff;
   assign rsp_bin_number = rsp_bin_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

// File: rtl/core/ddng_check.sv
`timescale 1ns / 1ps

module ddng_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [ddng_pkg::AMP_W-1:0]       req_noisy_amp,
   input logic [ddng_pkg::AMP_W-1:0]       req_noise_amp,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ddng_pkg::AMP_W-1:0]       rsp_clean_amp,
   input logic [ddng_pkg::BIN_W-1:0]       rsp_bin_number,
   input logic                             rsp_frame_end,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [ddng_pkg::IDX_W-1:0]       csr_index,
   input logic [ddng_pkg::CSR_W-1:0]       csr_wdata
);

   logic       req_acc;
   logic       rsp_acc;
   logic [9:0] owed_ff;
   logic [ddng_pkg::BIN_W-1:0] exp_bin_ff;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff    <= '0;
         exp_bin_ff <= '0;
      end else begin
         owed_ff <= owed_ff + 10'(req_acc) - 10'(rsp_acc);
         if (rsp_acc) begin
            exp_bin_ff <= rsp_frame_end ? '0 : rsp_bin_number + ddng_pkg::BIN_W'(1);
         end
      end
   end

   // held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_clean_amp)
                                 && $stable(rsp_bin_number) && $stable(rsp_frame_end))
      else $error("rsp beat changed while stalled");

   // no result without a request behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != '0)
      else $error("rsp beat without a pending request");

   // bins come out in order, restarting after frame_end
   a_bin_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> rsp_bin_number == exp_bin_ff)
      else $error("bin number out of sequence");

   // the configuration port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write not taken");

endmodule

bind decision_directed_noise_gain_top ddng_check u_check (.*);
